[rtl/rwcm_pkg.sv]
`timescale 1ns / 1ps

package rwcm_pkg;

    localparam int DATA_W  = 32;
    localparam int N_STEPS = DATA_W;

    localparam logic [4:0] MODE_CHECK  = 5'd1;
    localparam logic [4:0] MODE_CLAMP  = 5'd2;
    localparam logic [4:0] MODE_REPEAT = 5'd4;
    localparam logic [4:0] MODE_MIRROR = 5'd8;

    typedef struct packed {
        logic                     need_div;
        logic                     mirror;
        logic                     neg;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic        [DATA_W-1:0] span;
        logic signed [DATA_W-1:0] byp_val;
        logic                     byp_hdl;
    } t_ctx;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dq;
    } t_div;

endpackage

[rtl/rwcm_pre.sv]
`timescale 1ns / 1ps

module rwcm_pre (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_pass_through,
    input  logic [4:0]                        i_mode,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_range_low,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_range_high,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_value_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output rwcm_pkg::t_ctx                    o_ctx,
    output rwcm_pkg::t_div                    o_div
);

    localparam int W = rwcm_pkg::DATA_W;

    logic           r_valid;
    rwcm_pkg::t_ctx r_ctx;
    rwcm_pkg::t_div r_div;
    rwcm_pkg::t_ctx n_ctx;
    rwcm_pkg::t_div n_div;

    logic signed [W:0] w_span;
    logic signed [W:0] w_d;
    logic signed [W:0] w_dn;
    logic              w_span_pos;
    logic              w_ge_lo;
    logic              w_lt_hi;
    logic              w_inside;

    assign w_span     = {i_range_high[W-1], i_range_high} - {i_range_low[W-1], i_range_low};
    assign w_d        = {i_value_in[W-1], i_value_in} - {i_range_low[W-1], i_range_low};
    assign w_dn       = {i_range_low[W-1], i_range_low} - {i_value_in[W-1], i_value_in};
    assign w_span_pos = !w_span[W] && (w_span != '0);
    assign w_ge_lo    = i_value_in >= i_range_low;
    assign w_lt_hi    = i_value_in < i_range_high;
    assign w_inside   = w_ge_lo && w_lt_hi;

    always_comb begin
        n_ctx.need_div = 1'b0;
        n_ctx.mirror   = 1'b0;
        n_ctx.neg      = w_d[W];
        n_ctx.lo       = i_range_low;
        n_ctx.hi       = i_range_high;
        n_ctx.span     = w_span[W-1:0];
        n_ctx.byp_val  = i_value_in;
        n_ctx.byp_hdl  = 1'b0;
        n_div.rem      = '0;
        n_div.dq       = w_d[W] ? w_dn[W-1:0] : w_d[W-1:0];
        if (i_pass_through) begin
            n_ctx.byp_hdl = 1'b1;
        end else begin
            unique case (i_mode)
                rwcm_pkg::MODE_CHECK: begin
                    n_ctx.byp_hdl = w_inside;
                end
                rwcm_pkg::MODE_CLAMP: begin
                    n_ctx.byp_hdl = 1'b1;
                    if (!w_ge_lo) begin
                        n_ctx.byp_val = i_range_low;
                    end else if (!w_lt_hi) begin
                        n_ctx.byp_val = i_range_high;
                    end
                end
                rwcm_pkg::MODE_REPEAT: begin
                    if (w_inside) begin
                        n_ctx.byp_hdl = 1'b1;
                    end else begin
                        n_ctx.need_div = w_span_pos;
                    end
                end
                rwcm_pkg::MODE_MIRROR: begin
                    n_ctx.need_div = w_span_pos;
                    n_ctx.mirror   = 1'b1;
                end
                default: begin
                    n_ctx.byp_hdl = 1'b0;
                end
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctx <= n_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

endmodule

[rtl/rwcm_cell.sv]
`timescale 1ns / 1ps

module rwcm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rwcm_pkg::t_ctx i_ctx,
    input  rwcm_pkg::t_div i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output rwcm_pkg::t_ctx o_ctx,
    output rwcm_pkg::t_div o_div
);

    localparam int W = rwcm_pkg::DATA_W;

    logic           r_valid;
    rwcm_pkg::t_ctx r_ctx;
    rwcm_pkg::t_div r_div;
    rwcm_pkg::t_div n_div;

    logic [W+1:0] w_trial;
    logic         w_ge;

    assign w_trial = {1'b0, i_div.rem, i_div.dq[W-1]} - {2'b00, i_ctx.span};
    assign w_ge    = !w_trial[W+1];

    always_comb begin
        n_div.rem = w_ge ? w_trial[W-1:0] : {i_div.rem[W-2:0], i_div.dq[W-1]};
        n_div.dq  = {i_div.dq[W-2:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctx <= i_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_div   = r_div;

endmodule

[rtl/rwcm_post.sv]
`timescale 1ns / 1ps

module rwcm_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rwcm_pkg::t_ctx                    i_ctx,
    input  rwcm_pkg::t_div                    i_div,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rwcm_pkg::DATA_W-1:0] o_value_out,
    output logic                              o_handled
);

    localparam int W = rwcm_pkg::DATA_W;

    logic                r_valid;
    logic signed [W-1:0] r_val;
    logic                r_hdl;
    logic signed [W-1:0] n_val;
    logic                n_hdl;

    logic         w_adj;
    logic         w_use_hi;
    logic [W-1:0] w_lo_r;
    logic [W-1:0] w_hi_r;

    assign w_adj    = i_ctx.neg && (i_div.rem != '0);
    assign w_use_hi = w_adj ^ (i_ctx.mirror && (i_div.dq[0] ^ w_adj));
    assign w_lo_r   = i_ctx.lo + i_div.rem;
    assign w_hi_r   = i_ctx.hi - i_div.rem;

    always_comb begin
        if (i_ctx.need_div) begin
            n_val = w_use_hi ? w_hi_r : w_lo_r;
            n_hdl = 1'b1;
        end else begin
            n_val = i_ctx.byp_val;
            n_hdl = i_ctx.byp_hdl;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_val <= n_val;
            r_hdl <= n_hdl;
        end
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_val;
    assign o_handled   = r_hdl;

endmodule

[rtl/range_wrap_clamp_mirror.sv]
`timescale 1ns / 1ps

// Maps a signed fixed-point value into [range_low, range_high) by clamp, repeat
// or mirror mode, or checks it against that range in check mode. Each transaction
// passes one decode register, 32 divider cells that each resolve one quotient bit
// of the division of |value - low| by the span, and one output register.
// The cells form a pipeline, so one transaction is accepted every cycle while
// the output side keeps up; a stalled output fills empty cells before input stops.

module range_wrap_clamp_mirror (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_pass_through,
    input  logic [4:0]                        i_mode,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_range_low,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_range_high,
    input  logic signed [rwcm_pkg::DATA_W-1:0] i_value_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rwcm_pkg::DATA_W-1:0] o_value_out,
    output logic                              o_handled
);

    localparam int N = rwcm_pkg::N_STEPS;

    logic           w_valid [0:N];
    logic           w_rdy   [0:N];
    rwcm_pkg::t_ctx w_ctx   [0:N];
    rwcm_pkg::t_div w_div   [0:N];

    rwcm_pre u_pre (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pass_through (i_pass_through),
        .i_mode         (i_mode),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_value_in     (i_value_in),
        .o_valid        (w_valid[0]),
        .i_ready        (w_rdy[0]),
        .o_ctx          (w_ctx[0]),
        .o_div          (w_div[0])
    );

    for (genvar k = 1; k <= N; k++) begin : g_cell
        rwcm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k-1]),
            .o_ready (w_rdy[k-1]),
            .i_ctx   (w_ctx[k-1]),
            .i_div   (w_div[k-1]),
            .o_valid (w_valid[k]),
            .i_ready (w_rdy[k]),
            .o_ctx   (w_ctx[k]),
            .o_div   (w_div[k])
        );
    end

    rwcm_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[N]),
        .o_ready     (w_rdy[N]),
        .i_ctx       (w_ctx[N]),
        .i_div       (w_div[N]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_out (o_value_out),
        .o_handled   (o_handled)
    );

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[N] && w_ctx[N].need_div |-> w_div[N].rem < w_ctx[N].span)
        else $error("remainder not below span");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] && w_ctx[0].need_div |-> w_ctx[0].span != '0)
        else $error("division issued with empty span");

    a_last_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[N] && !w_rdy[N] |=> w_valid[N] && $stable(w_div[N]))
        else $error("last cell dropped a stalled transaction");

endmodule
